// File: src/ndpc_pkg.sv
// ----------------------------------------------------------------------------
// ndpc_pkg
// Types and constants shared by the Newmark predictor/corrector block.
// ----------------------------------------------------------------------------
package ndpc_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned REG_W     = 33;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_LANES = 5;

  localparam logic signed [VALUE_W-1:0] ONE     = 64'sh0000_0001_0000_0000;
  localparam logic signed [VALUE_W-1:0] HALF    = 64'sh0000_0000_8000_0000;
  localparam logic signed [VALUE_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ACT_PREDICT,
    ACT_ACCEL_CORR,
    ACT_VELOC_CORR,
    ACT_DISPL_CORR
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP,
    REG_ALPHA,
    REG_BETA,
    REG_PRED_VEL,
    REG_PRED_ACC
  } reg_idx_e;

  // coefficient sequencer
  typedef enum logic [2:0] {
    CS_LOAD,
    CS_MUL,
    CS_MSGN,
    CS_MRND,
    CS_DIV,
    CS_DFIN,
    CS_DONE
  } cstate_e;

  // one entry per coefficient computation, in order
  typedef enum logic [3:0] {
    ST_KA,
    ST_CUV,
    ST_HA,
    ST_HAB,
    ST_CUA0,
    ST_CUA,
    ST_HB,
    ST_CVA,
    ST_AB,
    ST_ABT,
    ST_ACC_E,
    ST_ACC_D,
    ST_VEL_E,
    ST_VEL_C,
    ST_DIS_D,
    ST_DIS_C
  } step_e;

  typedef struct packed {
    action_e                    action;
    logic signed [VALUE_W-1:0]  disp;
    logic signed [VALUE_W-1:0]  vel;
    logic signed [VALUE_W-1:0]  accel;
    logic signed [VALUE_W-1:0]  correction;
    logic                       blocked;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_disp;
    logic signed [VALUE_W-1:0] new_vel;
    logic signed [VALUE_W-1:0] new_accel;
  } out_t;

  typedef struct packed {
    logic [REG_W-1:0] time_step;
    logic [REG_W-1:0] alpha_weight;
    logic [REG_W-1:0] beta_weight;
    logic [REG_W-1:0] pred_vel_weight;
    logic [REG_W-1:0] pred_acc_weight;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cuv;
    logic signed [VALUE_W-1:0] cua;
    logic signed [VALUE_W-1:0] cvv;
    logic signed [VALUE_W-1:0] cva;
    logic signed [VALUE_W-1:0] caa;
    logic signed [VALUE_W-1:0] acc_e;
    logic signed [VALUE_W-1:0] acc_d;
    logic signed [VALUE_W-1:0] vel_e;
    logic signed [VALUE_W-1:0] vel_c;
    logic signed [VALUE_W-1:0] dis_d;
    logic signed [VALUE_W-1:0] dis_c;
  } coef_t;

endpackage

// File: src/ndpc_coef.sv
// ----------------------------------------------------------------------------
// ndpc_coef
// Coefficient sequencer: bit-serial multiplier and restoring divider derive
// all item coefficients but cvv and caa from the configuration registers.
// ----------------------------------------------------------------------------
module ndpc_coef (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  ndpc_pkg::cfg_t  cfg_i,
  output logic            busy_o,
  output ndpc_pkg::coef_t coef_o
);

  ndpc_pkg::cstate_e state_q, state_d;
  ndpc_pkg::step_e   step_q, step_d;
  logic [6:0]          cnt_q, cnt_d;
  logic [63:0]         ma_q, ma_d, mb_q, mb_d;
  logic                neg_q, neg_d;
  logic [127:0]        prod_q, prod_d;
  logic signed [128:0] wide_q, wide_d;
  logic [63:0]         den_q, den_d, rem_q, rem_d;
  logic [64:0]         quo_q, quo_d;

  logic signed [63:0] cuv_q, cua_q, cva_q, acc_e_q, acc_d_q, vel_e_q;
  logic signed [63:0] vel_c_q, dis_d_q, dis_c_q, prev_q;

  logic signed [63:0] dt, al, be, kw, hw;
  logic signed [63:0] op_a, op_b, div_src;
  logic               is_div;
  logic signed [63:0] res;
  logic               res_we;

  logic [64:0]         msum;
  logic [64:0]         r2;
  logic                ge;
  logic                rup;
  logic [65:0]         q2;
  logic signed [128:0] rsum;
  logic signed [96:0]  rsh;

  assign dt = $signed({31'd0, cfg_i.time_step});
  assign al = $signed({31'd0, cfg_i.alpha_weight});
  assign be = $signed({31'd0, cfg_i.beta_weight});
  assign kw = $signed({31'd0, cfg_i.pred_vel_weight});
  assign hw = $signed({31'd0, cfg_i.pred_acc_weight});

  // operand selection per step; prev is the last product
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    div_src = '0;
    is_div  = 1'b0;
    unique case (step_q)
      ndpc_pkg::ST_KA:    begin op_a = kw; op_b = al; end
      ndpc_pkg::ST_CUV:   begin op_a = ndpc_pkg::ONE - prev_q; op_b = dt; end
      ndpc_pkg::ST_HA:    begin op_a = hw; op_b = al; end
      ndpc_pkg::ST_HAB:   begin op_a = prev_q; op_b = be; end
      ndpc_pkg::ST_CUA0:  begin op_a = ndpc_pkg::HALF - prev_q; op_b = dt; end
      ndpc_pkg::ST_CUA:   begin op_a = prev_q; op_b = dt; end
      ndpc_pkg::ST_HB:    begin op_a = hw; op_b = be; end
      ndpc_pkg::ST_CVA:   begin op_a = ndpc_pkg::ONE - prev_q; op_b = dt; end
      ndpc_pkg::ST_AB:    begin op_a = al; op_b = be; end
      ndpc_pkg::ST_ABT:   begin op_a = prev_q; op_b = dt; end
      ndpc_pkg::ST_ACC_E: begin op_a = prev_q; op_b = dt; end
      ndpc_pkg::ST_ACC_D: begin op_a = be; op_b = dt; end
      ndpc_pkg::ST_VEL_E: begin op_a = al; op_b = dt; end
      ndpc_pkg::ST_VEL_C: begin div_src = acc_d_q; is_div = 1'b1; end
      ndpc_pkg::ST_DIS_D: begin div_src = vel_e_q; is_div = 1'b1; end
      ndpc_pkg::ST_DIS_C: begin div_src = acc_e_q; is_div = 1'b1; end
      default:            begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    wide_d  = wide_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    res     = '0;
    res_we  = 1'b0;

    msum = {1'b0, prod_q[127:64]} + (mb_q[0] ? {1'b0, ma_q} : 65'd0);
    r2   = {rem_q, (cnt_q == 7'd0)};
    ge   = r2 >= {1'b0, den_q};
    rup  = {rem_q, 1'b0} >= {1'b0, den_q};
    q2   = {1'b0, quo_q} + {65'd0, rup};
    rsum = wide_q + {65'd0, ndpc_pkg::HALF};
    rsh  = rsum[128:32];

    unique case (state_q)
      ndpc_pkg::CS_LOAD: begin
        cnt_d = '0;
        if (is_div) begin
          if (div_src[63] || div_src == 64'sd0) begin
            res    = ndpc_pkg::S64_MAX;
            res_we = 1'b1;
          end else begin
            den_d   = div_src;
            rem_d   = '0;
            quo_d   = '0;
            state_d = ndpc_pkg::CS_DIV;
          end
        end else begin
          ma_d    = op_a[63] ? 64'(-op_a) : op_a;
          mb_d    = op_b[63] ? 64'(-op_b) : op_b;
          neg_d   = op_a[63] ^ op_b[63];
          prod_d  = '0;
          state_d = ndpc_pkg::CS_MUL;
        end
      end
      ndpc_pkg::CS_MUL: begin
        prod_d = {msum, prod_q[63:1]};
        mb_d   = mb_q >> 1;
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = ndpc_pkg::CS_MSGN;
      end
      ndpc_pkg::CS_MSGN: begin
        wide_d  = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
        state_d = ndpc_pkg::CS_MRND;
      end
      ndpc_pkg::CS_MRND: begin
        if (rsh[96:63] == '0 || rsh[96:63] == '1) res = rsh[63:0];
        else res = rsh[96] ? ndpc_pkg::S64_MIN : ndpc_pkg::S64_MAX;
        res_we = 1'b1;
      end
      ndpc_pkg::CS_DIV: begin
        rem_d = ge ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
        quo_d = {quo_q[63:0], ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) state_d = ndpc_pkg::CS_DFIN;
      end
      ndpc_pkg::CS_DFIN: begin
        res    = (q2 > {2'b00, ndpc_pkg::S64_MAX}) ? ndpc_pkg::S64_MAX : q2[63:0];
        res_we = 1'b1;
      end
      ndpc_pkg::CS_DONE: ;
      default: state_d = ndpc_pkg::CS_DONE;
    endcase

    if (res_we) begin
      if (step_q == ndpc_pkg::ST_DIS_C) begin
        state_d = ndpc_pkg::CS_DONE;
      end else begin
        step_d  = ndpc_pkg::step_e'(step_q + 4'd1);
        state_d = ndpc_pkg::CS_LOAD;
      end
    end

    if (restart_i) begin
      state_d = ndpc_pkg::CS_LOAD;
      step_d  = ndpc_pkg::ST_KA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ndpc_pkg::CS_LOAD;
      step_q  <= ndpc_pkg::ST_KA;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    wide_q <= wide_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (res_we) begin
      prev_q <= res;
      unique case (step_q)
        ndpc_pkg::ST_CUV:   cuv_q   <= res;
        ndpc_pkg::ST_CUA:   cua_q   <= res;
        ndpc_pkg::ST_CVA:   cva_q   <= res;
        ndpc_pkg::ST_ACC_E: acc_e_q <= res;
        ndpc_pkg::ST_ACC_D: acc_d_q <= res;
        ndpc_pkg::ST_VEL_E: vel_e_q <= res;
        ndpc_pkg::ST_VEL_C: vel_c_q <= res;
        ndpc_pkg::ST_DIS_D: dis_d_q <= res;
        ndpc_pkg::ST_DIS_C: dis_c_q <= res;
        default: ;
      endcase
    end
  end

  assign busy_o = state_q != ndpc_pkg::CS_DONE;

  assign coef_o.cuv   = cuv_q;
  assign coef_o.cua   = cua_q;
  assign coef_o.cvv   = ndpc_pkg::ONE - kw;
  assign coef_o.cva   = cva_q;
  assign coef_o.caa   = ndpc_pkg::ONE - hw;
  assign coef_o.acc_e = acc_e_q;
  assign coef_o.acc_d = acc_d_q;
  assign coef_o.vel_e = vel_e_q;
  assign coef_o.vel_c = vel_c_q;
  assign coef_o.dis_d = dis_d_q;
  assign coef_o.dis_c = dis_c_q;

endmodule

// File: src/newmark_dof_predict_correct.sv
// ----------------------------------------------------------------------------
// newmark_dof_predict_correct
// Newmark-beta predictor / corrector for one degree of freedom per item.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one dof (action, disp, vel,
// accel, correction, blocked). Output channel: out_valid_o / out_stall_i
// carry new_disp, new_vel, new_accel. An item moves when valid is high and
// stall is low.
// Datapath: five register stages (operand select, 32x32 partial products,
// product sum, accumulate with rounding, saturate), one item per cycle
// sustained while not stalled; bubbles collapse while the output stalls.
// Coefficients come from a serial sequencer of 13 multiplies and 3 divides
// that runs after reset and after every configuration write; in_stall_o
// stays high until it finishes. Configuration registers return to their
// reset values. When out_stall_i is high the output item holds and upstream
// stages fill; in_stall_o rises once the first stage has nowhere to go.
// ----------------------------------------------------------------------------
module newmark_dof_predict_correct (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ndpc_pkg::in_t                      in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ndpc_pkg::out_t                     out_item_o,
  input  logic                               cfg_we_i,
  input  logic [ndpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ndpc_pkg::REG_W-1:0]         cfg_data_i
);

  localparam int unsigned NL = ndpc_pkg::NUM_LANES;

  ndpc_pkg::cfg_t  cfg_q;
  ndpc_pkg::coef_t coef;
  logic            busy;

  logic [4:0] v_q;
  logic [4:0] en;

  logic signed [63:0] m_d [NL];
  logic signed [63:0] o_d [NL];
  logic signed [63:0] b_d [3];
  logic signed [63:0] m_q [NL];
  logic signed [63:0] o_q [NL];
  logic signed [63:0] b1_q [3];

  logic [63:0]        ll_d [NL];
  logic signed [64:0] lh_d [NL];
  logic signed [64:0] hl_d [NL];
  logic signed [63:0] hh_d [NL];
  logic [63:0]        ll_q [NL];
  logic signed [64:0] lh_q [NL];
  logic signed [64:0] hl_q [NL];
  logic signed [63:0] hh_q [NL];
  logic signed [63:0] b2_q [3];

  logic signed [65:0]  mid [NL];
  logic signed [127:0] p_d [NL];
  logic signed [127:0] p_q [NL];
  logic signed [63:0]  b3_q [3];

  logic signed [129:0] t_d [3];
  logic signed [129:0] t_q [3];

  ndpc_pkg::out_t out_d, out_q;

  function automatic logic signed [129:0] ext130(input logic signed [127:0] p);
    ext130 = {{2{p[127]}}, p};
  endfunction

  function automatic logic signed [129:0] base130(input logic signed [63:0] b);
    base130 = {{34{b[63]}}, b, 32'd0};
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [129:0] t);
    logic [97:0] sh;
    sh = t[129:32];
    if (sh[97:63] == '0 || sh[97:63] == '1) sat64 = sh[63:0];
    else sat64 = sh[97] ? ndpc_pkg::S64_MIN : ndpc_pkg::S64_MAX;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step       <= 33'd42950;
      cfg_q.alpha_weight    <= 33'h0_8000_0000;
      cfg_q.beta_weight     <= 33'h0_8000_0000;
      cfg_q.pred_vel_weight <= '0;
      cfg_q.pred_acc_weight <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ndpc_pkg::REG_TIME_STEP: cfg_q.time_step       <= cfg_data_i;
        ndpc_pkg::REG_ALPHA:     cfg_q.alpha_weight    <= cfg_data_i;
        ndpc_pkg::REG_BETA:      cfg_q.beta_weight     <= cfg_data_i;
        ndpc_pkg::REG_PRED_VEL:  cfg_q.pred_vel_weight <= cfg_data_i;
        ndpc_pkg::REG_PRED_ACC:  cfg_q.pred_acc_weight <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ndpc_coef u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .cfg_i     (cfg_q),
    .busy_o    (busy),
    .coef_o    (coef)
  );

  // stage handshake
  assign en[4] = !v_q[4] || !out_stall_i;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  assign in_stall_o = busy || cfg_we_i || !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i && !in_stall_o;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: pick coefficient / operand pairs per lane
  // lanes 0,1 feed disp, lanes 2,3 feed vel, lane 4 feeds accel
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      m_d[i] = '0;
      o_d[i] = '0;
    end
    b_d[0] = in_item_i.disp;
    b_d[1] = in_item_i.vel;
    b_d[2] = in_item_i.accel;
    if (!in_item_i.blocked) begin
      unique case (in_item_i.action)
        ndpc_pkg::ACT_PREDICT: begin
          m_d[0] = coef.cuv; o_d[0] = in_item_i.vel;
          m_d[1] = coef.cua; o_d[1] = in_item_i.accel;
          m_d[2] = coef.cvv; o_d[2] = in_item_i.vel;
          m_d[3] = coef.cva; o_d[3] = in_item_i.accel;
          m_d[4] = coef.caa; o_d[4] = in_item_i.accel;
          b_d[1] = '0;
          b_d[2] = '0;
        end
        ndpc_pkg::ACT_ACCEL_CORR: begin
          m_d[0] = coef.acc_e;   o_d[0] = in_item_i.correction;
          m_d[2] = coef.acc_d;   o_d[2] = in_item_i.correction;
          m_d[4] = ndpc_pkg::ONE; o_d[4] = in_item_i.correction;
        end
        ndpc_pkg::ACT_VELOC_CORR: begin
          m_d[0] = coef.vel_e;   o_d[0] = in_item_i.correction;
          m_d[2] = ndpc_pkg::ONE; o_d[2] = in_item_i.correction;
          m_d[4] = coef.vel_c;   o_d[4] = in_item_i.correction;
        end
        ndpc_pkg::ACT_DISPL_CORR: begin
          m_d[0] = ndpc_pkg::ONE; o_d[0] = in_item_i.correction;
          m_d[2] = coef.dis_d;   o_d[2] = in_item_i.correction;
          m_d[4] = coef.dis_c;   o_d[4] = in_item_i.correction;
        end
        default: ;
      endcase
    end
  end

  // stage 2: 32x32 partial products
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ll_d[i] = m_q[i][31:0] * o_q[i][31:0];
      lh_d[i] = $signed({1'b0, m_q[i][31:0]}) * $signed(o_q[i][63:32]);
      hl_d[i] = $signed(m_q[i][63:32]) * $signed({1'b0, o_q[i][31:0]});
      hh_d[i] = $signed(m_q[i][63:32]) * $signed(o_q[i][63:32]);
    end
  end

  // stage 3: full products
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      mid[i] = {lh_q[i][64], lh_q[i]} + {hl_q[i][64], hl_q[i]};
      p_d[i] = {hh_q[i], 64'd0} + {{30{mid[i][65]}}, mid[i], 32'd0}
             + {64'd0, ll_q[i]};
    end
  end

  // stage 4: sums with base and rounding half
  always_comb begin
    t_d[0] = ext130(p_q[0]) + ext130(p_q[1]) + base130(b3_q[0])
           + {66'd0, ndpc_pkg::HALF};
    t_d[1] = ext130(p_q[2]) + ext130(p_q[3]) + base130(b3_q[1])
           + {66'd0, ndpc_pkg::HALF};
    t_d[2] = ext130(p_q[4]) + base130(b3_q[2]) + {66'd0, ndpc_pkg::HALF};
  end

  // stage 5: shift out fraction and saturate
  assign out_d.new_disp  = sat64(t_q[0]);
  assign out_d.new_vel   = sat64(t_q[1]);
  assign out_d.new_accel = sat64(t_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_q  <= m_d;
      o_q  <= o_d;
      b1_q <= b_d;
    end
    if (en[1]) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      b2_q <= b1_q;
    end
    if (en[2]) begin
      p_q  <= p_d;
      b3_q <= b2_q;
    end
    if (en[3]) t_q <= t_d;
    if (en[4]) out_q <= out_d;
  end

  assign out_valid_o = v_q[4];
  assign out_item_o  = out_q;

endmodule

// File: src/ndpc_checker.sv
// ----------------------------------------------------------------------------
// ndpc_checker
// Port-level checks for the Newmark predictor/corrector block.
// ----------------------------------------------------------------------------
module ndpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input ndpc_pkg::out_t                 out_item_o,
  input logic                           cfg_we_i
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  // no item enters while a register write lands
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && in_valid_i |-> in_stall_o)
    else $error("item accepted during config write");

  // coefficients are recomputed after a write
  a_cfg_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input open right after config write");

  // coefficients are computed after reset before any item enters
  a_reset_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open right after reset");

endmodule

bind newmark_dof_predict_correct ndpc_checker u_ndpc_checker (.*);

// File: bench/newmark_dof_predict_correct_test.sv
// ----------------------------------------------------------------------------
// newmark_dof_predict_correct_test
// Self-checking bench for the Newmark predictor/corrector. A short directed
// table comes first, then random dof items under several register settings.
// Each output is checked by its typed row or an internal wide fixed-point model.
// ----------------------------------------------------------------------------
module newmark_dof_predict_correct_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PER_SET = 115;

  typedef logic signed [131:0] wide_t;

  typedef struct {
    ndpc_pkg::in_t  item;
    bit             typed;
    ndpc_pkg::out_t want;
  } dof_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ndpc_pkg::in_t  in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ndpc_pkg::out_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [ndpc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ndpc_pkg::REG_W-1:0] cfg_data_i = '0;

  // typed expectation travelling with the item on the input port
  bit   row_typed = 1'b0;
  ndpc_pkg::out_t row_want = '0;

  // register shadow
  logic [ndpc_pkg::REG_W-1:0] dt_w = 33'd42950;
  logic [ndpc_pkg::REG_W-1:0] alpha_w = 33'h0_8000_0000;
  logic [ndpc_pkg::REG_W-1:0] beta_w = 33'h0_8000_0000;
  logic [ndpc_pkg::REG_W-1:0] kvel_w = '0;
  logic [ndpc_pkg::REG_W-1:0] hacc_w = '0;

  ndpc_pkg::out_t pending_dofs[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned dofs_sent = 0;
  int unsigned dofs_checked = 0;
  int unsigned reg_sets = 0;
  bit quiet = 1'b0;     // no idling on either side
  bit hold_req = 1'b0;  // receiver holds off for a long stretch

  newmark_dof_predict_correct i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o,
    .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---- fixed-point model ----
  function automatic wide_t round_q(wide_t w);
    return (w + (wide_t'(1) <<< (ndpc_pkg::FRAC_BITS - 1))) >>> ndpc_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] clamp64(wide_t w);
    if (w > wide_t'(ndpc_pkg::S64_MAX)) return ndpc_pkg::S64_MAX;
    if (w < wide_t'(ndpc_pkg::S64_MIN)) return ndpc_pkg::S64_MIN;
    return w[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a,
                                              logic signed [63:0] b);
    return clamp64(round_q(wide_t'(a) * wide_t'(b)));
  endfunction

  function automatic logic signed [63:0] recip(logic signed [63:0] d);
    logic [131:0] num, q, r;
    if (d <= 0) return ndpc_pkg::S64_MAX;
    num = 132'd1 << (2 * ndpc_pkg::FRAC_BITS);
    q = num / d;
    r = num % d;
    if (2 * r >= d) q = q + 1;
    return clamp64($signed(q));
  endfunction

  function automatic ndpc_pkg::out_t newmark_update(ndpc_pkg::in_t d);
    logic signed [63:0] dt, al, be, kw, hw, e, dv, c;
    logic signed [63:0] cuv, cua, cvv, cva, caa, ab2;
    wide_t u, v, a, x;
    ndpc_pkg::out_t r;
    dt = $signed({31'b0, dt_w});
    al = $signed({31'b0, alpha_w});
    be = $signed({31'b0, beta_w});
    kw = $signed({31'b0, kvel_w});
    hw = $signed({31'b0, hacc_w});
    u = wide_t'(d.disp);
    v = wide_t'(d.vel);
    a = wide_t'(d.accel);
    x = wide_t'(d.correction);
    if (d.blocked) begin
      r.new_disp = d.disp;
      r.new_vel = d.vel;
      r.new_accel = d.accel;
      return r;
    end
    ab2 = qmul(qmul(qmul(al, be), dt), dt);
    if (d.action == ndpc_pkg::ACT_PREDICT) begin
      cuv = qmul(ndpc_pkg::ONE - qmul(kw, al), dt);
      cua = qmul(qmul(ndpc_pkg::HALF - qmul(qmul(hw, al), be), dt), dt);
      cvv = ndpc_pkg::ONE - kw;
      cva = qmul(ndpc_pkg::ONE - qmul(hw, be), dt);
      caa = ndpc_pkg::ONE - hw;
      r.new_disp = clamp64(u + round_q(wide_t'(cuv) * v + wide_t'(cua) * a));
      r.new_vel = clamp64(round_q(wide_t'(cvv) * v + wide_t'(cva) * a));
      r.new_accel = clamp64(round_q(wide_t'(caa) * a));
      return r;
    end
    case (d.action)
      ndpc_pkg::ACT_ACCEL_CORR: begin
        e = ab2; dv = qmul(be, dt); c = ndpc_pkg::ONE;
      end
      ndpc_pkg::ACT_VELOC_CORR: begin
        e = qmul(al, dt); dv = ndpc_pkg::ONE; c = recip(qmul(be, dt));
      end
      default: begin
        e = ndpc_pkg::ONE; dv = recip(qmul(al, dt)); c = recip(ab2);
      end
    endcase
    r.new_disp = clamp64(u + round_q(wide_t'(e) * x));
    r.new_vel = clamp64(v + round_q(wide_t'(dv) * x));
    r.new_accel = clamp64(a + round_q(wide_t'(c) * x));
    return r;
  endfunction

  // ---- expectation capture and output check ----
  task automatic report(string what, logic signed [63:0] got, logic signed [63:0] want);
    mismatches++;
    $display("[%0d] %s: got %h want %h", cycles, what, got, want);
  endtask

  always @(posedge clk_i) begin
    ndpc_pkg::out_t w;
    if (in_valid_i && !in_stall_o)
      pending_dofs.push_back(row_typed ? row_want : newmark_update(in_item_i));
    if (out_valid_o && !out_stall_i) begin
      dofs_checked++;
      if (pending_dofs.size() == 0) begin
        report("output item with nothing expected", out_item_o.new_disp, 64'sd0);
      end else begin
        w = pending_dofs.pop_front();
        if (out_item_o.new_disp !== w.new_disp)
          report("new_disp", out_item_o.new_disp, w.new_disp);
        if (out_item_o.new_vel !== w.new_vel)
          report("new_vel", out_item_o.new_vel, w.new_vel);
        if (out_item_o.new_accel !== w.new_accel)
          report("new_accel", out_item_o.new_accel, w.new_accel);
      end
    end
  end

  // ---- receiver stall ----
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < 300; held++) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 30);
      end
    end
  end

  // ---- sender ----
  task automatic send_dof(ndpc_pkg::in_t d, bit typed, ndpc_pkg::out_t want);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= d;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    dofs_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_dofs.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [ndpc_pkg::REG_W-1:0] dt, logic [ndpc_pkg::REG_W-1:0] al,
                          logic [ndpc_pkg::REG_W-1:0] be, logic [ndpc_pkg::REG_W-1:0] kw,
                          logic [ndpc_pkg::REG_W-1:0] hw);
    logic [ndpc_pkg::REG_W-1:0] vals[5];
    ndpc_pkg::reg_idx_e idx;
    drain();
    vals = '{dt, al, be, kw, hw};
    idx = ndpc_pkg::REG_TIME_STEP;
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    dt_w = dt; alpha_w = al; beta_w = be; kvel_w = kw; hacc_w = hw;
    reg_sets++;
  endtask

  function automatic logic signed [63:0] rand_value();
    logic signed [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return ndpc_pkg::S64_MAX;
      1: return ndpc_pkg::S64_MIN;
      2, 3, 4: return r >>> $urandom_range(20, 40);  // at most 2^11 units in magnitude, Q32.32
      default: return r;
    endcase
  endfunction

  function automatic ndpc_pkg::in_t rand_dof();
    ndpc_pkg::in_t d;
    d.action = ndpc_pkg::action_e'($urandom_range(3));
    d.disp = rand_value();
    d.vel = rand_value();
    d.accel = rand_value();
    d.correction = rand_value();
    d.blocked = ($urandom_range(7) == 0);
    return d;
  endfunction

  // sender pauses for all results at a quarter, receiver holds off at two thirds
  task automatic random_burst(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      quiet = (i >= n / 3) && (i < n / 3 + 30);
      if (i == n / 4) drain();
      if (i == 2 * n / 3) hold_req = 1'b1;
      send_dof(rand_dof(), 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  dof_row_t dof_table[$];

  function automatic void add_row(ndpc_pkg::action_e act, logic signed [63:0] u,
                                  logic signed [63:0] v, logic signed [63:0] a,
                                  logic signed [63:0] x, logic blk, bit typed);
    dof_row_t r;
    r.item = '{action: act, disp: u, vel: v, accel: a, correction: x, blocked: blk};
    r.typed = typed;
    r.want = '{new_disp: u, new_vel: v, new_accel: a};
    dof_table.push_back(r);
  endfunction

  initial begin
    int unsigned wait_cycles;
    // blocked dofs and zero corrections pass through unchanged
    add_row(ndpc_pkg::ACT_PREDICT, ndpc_pkg::S64_MAX, ndpc_pkg::S64_MIN, ndpc_pkg::ONE,
            ndpc_pkg::S64_MAX, 1'b1, 1'b1);
    add_row(ndpc_pkg::ACT_DISPL_CORR, ndpc_pkg::S64_MIN, ndpc_pkg::S64_MAX, -ndpc_pkg::ONE,
            ndpc_pkg::S64_MIN, 1'b1, 1'b1);
    add_row(ndpc_pkg::ACT_ACCEL_CORR, ndpc_pkg::S64_MAX, ndpc_pkg::S64_MIN, 64'sd7,
            64'sd0, 1'b0, 1'b1);
    add_row(ndpc_pkg::ACT_VELOC_CORR, ndpc_pkg::S64_MIN, ndpc_pkg::S64_MAX, -64'sd1,
            64'sd0, 1'b0, 1'b1);
    add_row(ndpc_pkg::ACT_DISPL_CORR, -ndpc_pkg::ONE, ndpc_pkg::HALF, ndpc_pkg::S64_MIN,
            64'sd0, 1'b0, 1'b1);
    add_row(ndpc_pkg::ACT_PREDICT, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0, 1'b0);
    add_row(ndpc_pkg::ACT_PREDICT, ndpc_pkg::S64_MAX, ndpc_pkg::S64_MAX, ndpc_pkg::S64_MAX,
            64'sd0, 1'b0, 1'b0);
    add_row(ndpc_pkg::ACT_PREDICT, ndpc_pkg::S64_MIN, ndpc_pkg::S64_MIN, ndpc_pkg::S64_MIN,
            ndpc_pkg::S64_MAX, 1'b0, 1'b0);
    add_row(ndpc_pkg::ACT_PREDICT, ndpc_pkg::ONE, -ndpc_pkg::ONE, ndpc_pkg::HALF, 64'sd0,
            1'b0, 1'b0);
    for (int i = 1; i < 4; i++) begin
      add_row(ndpc_pkg::action_e'(i), 64'sd0, 64'sd0, 64'sd0, ndpc_pkg::ONE, 1'b0, 1'b0);
      add_row(ndpc_pkg::action_e'(i), ndpc_pkg::S64_MAX, ndpc_pkg::S64_MAX,
              ndpc_pkg::S64_MAX, ndpc_pkg::S64_MAX, 1'b0, 1'b0);
      add_row(ndpc_pkg::action_e'(i), ndpc_pkg::S64_MIN, ndpc_pkg::S64_MIN,
              ndpc_pkg::S64_MIN, ndpc_pkg::S64_MIN, 1'b0, 1'b0);
      add_row(ndpc_pkg::action_e'(i), ndpc_pkg::ONE, -ndpc_pkg::ONE, ndpc_pkg::HALF,
              -64'sd1, 1'b0, 1'b0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dof_table[i])
      send_dof(dof_table[i].item, dof_table[i].typed, dof_table[i].want);
    random_burst(RAND_PER_SET);

    // typical values, then extremes and zero divisors
    set_regs(33'd4295, 33'h0_4000_0000, 33'h0_C000_0000, 33'h0_3000_0000,
             33'h0_9000_0000);
    random_burst(RAND_PER_SET);
    set_regs(33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000,
             33'h1_0000_0000);
    random_burst(RAND_PER_SET);
    set_regs(33'd1, 33'd0, 33'd0, 33'd0, 33'd0);
    random_burst(RAND_PER_SET);
    set_regs(33'h0_8000_0000, 33'd0, 33'h0_0000_0003, 33'h1_0000_0000, 33'd0);
    random_burst(RAND_PER_SET);
    set_regs({1'b0, $urandom_range(32'hFFFF_FFFF, 1)}, {1'b0, $urandom},
             {1'b0, $urandom}, {1'b0, $urandom}, {1'b0, $urandom});
    random_burst(RAND_PER_SET);

    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_dofs.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    $display("sent %0d dof items over %0d register settings, %0d outputs checked",
             dofs_sent, reg_sets + 1, dofs_checked);
    $display("actions: predict and all three correctors, blocked, saturation, zero divisors");
    if (mismatches == 0 && pending_dofs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d items never came out", mismatches,
               pending_dofs.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: newmark_dof_predict_correct.f
src/ndpc_pkg.sv
src/ndpc_coef.sv
src/newmark_dof_predict_correct.sv
src/ndpc_checker.sv
bench/newmark_dof_predict_correct_test.sv
